// ===== sv/jbps_pkg.sv =====
package jbps_pkg;

    // Field widths of the request and result channels.
    localparam int CODE_WORD_W = 24;
    localparam int CODE_LEN_W  = 5;
    localparam int S_TDATA_W   = 32;
    localparam int BYTE_W      = 8;
    localparam int PEND_W      = 7;
    localparam int PCOUNT_W    = 3;

    // Default longest code word and depth of the job queue.
    localparam int MAX_CODE_LEN_DEF = 24;
    localparam int QUEUE_DEPTH_DEF  = 2;

    // Marker byte that triggers a stuffed zero, and the stuffed value.
    localparam logic [BYTE_W-1:0] BYTE_MARKER = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_STUFF  = 8'h00;

    // Reset value of the stuffing enable register.
    localparam logic STUFF_ENABLE_RST = 1'b1;

endpackage

// ===== sv/jbps_front.sv =====
module jbps_front #(
    parameter int MAX_CODE_LEN = jbps_pkg::MAX_CODE_LEN_DEF,
    parameter int ACC_W        = MAX_CODE_LEN + jbps_pkg::PEND_W,
    parameter int NB_MAX       = ACC_W / 8,
    parameter int JOB_W        = NB_MAX * 8,
    parameter int CNT_W        = $clog2(NB_MAX + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                req_valid,
    input  logic [jbps_pkg::CODE_WORD_W-1:0]    code_word,
    input  logic [jbps_pkg::CODE_LEN_W-1:0]     code_len,
    input  logic                                queue_full,
    output logic                                req_ready,
    output logic                                job_push,
    output logic [JOB_W-1:0]                    job_data,
    output logic [CNT_W-1:0]                    job_count
);

    localparam int TOT_W = $clog2(ACC_W + 1);
    localparam int SH_W  = $clog2(JOB_W + 1);

    logic [jbps_pkg::PEND_W-1:0]   pend_bits_reg;
    logic [jbps_pkg::PEND_W-1:0]   pend_bits_next;
    logic [jbps_pkg::PCOUNT_W-1:0] pend_count_reg;
    logic [jbps_pkg::PCOUNT_W-1:0] pend_count_next;

    logic [jbps_pkg::CODE_LEN_W-1:0] len_sat;
    logic [ACC_W-1:0]                word_mask;
    logic [ACC_W-1:0]                acc;
    logic [ACC_W-1:0]                whole;
    logic [TOT_W-1:0]                total;
    logic [SH_W-1:0]                 shamt;
    logic                            accept;

    assign req_ready = !queue_full;
    assign accept    = req_valid && req_ready;

    // Saturate the length, mask the word and join it behind the pending bits.
    always_comb begin
        if (code_len > jbps_pkg::CODE_LEN_W'(MAX_CODE_LEN)) begin
            len_sat = jbps_pkg::CODE_LEN_W'(MAX_CODE_LEN);
        end else begin
            len_sat = code_len;
        end
        word_mask = (ACC_W'(1) << len_sat) - ACC_W'(1);
        acc       = (ACC_W'(pend_bits_reg) << len_sat) | (ACC_W'(code_word) & word_mask);
        total     = TOT_W'(pend_count_reg) + TOT_W'(len_sat);
    end

    // Split into whole bytes, left aligned for the back end, and leftover bits.
    always_comb begin
        job_count       = CNT_W'(total >> 3);
        pend_count_next = total[jbps_pkg::PCOUNT_W-1:0];
        pend_bits_next  = acc[jbps_pkg::PEND_W-1:0]
                        & ((jbps_pkg::PEND_W'(1) << pend_count_next) - jbps_pkg::PEND_W'(1));
        whole           = acc >> pend_count_next;
        shamt           = SH_W'(JOB_W - 8 * int'(job_count));
        job_data        = JOB_W'(whole) << shamt;
        job_push        = accept && (job_count != '0);
    end

    // Pending bit state is updated as each request is accepted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg  <= '0;
            pend_count_reg <= '0;
        end else if (accept) begin
            pend_bits_reg  <= pend_bits_next;
            pend_count_reg <= pend_count_next;
        end
    end

endmodule

// ===== sv/jbps_fifo.sv =====
module jbps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = jbps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count bookkeeping with wrap at the queue depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage holds payload only.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/jbps_back.sv =====
module jbps_back #(
    parameter int JOB_W = 24,
    parameter int CNT_W = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          stuff_enable,
    input  logic                          queue_empty,
    input  logic [JOB_W-1:0]              job_data,
    input  logic [CNT_W-1:0]              job_count,
    output logic                          queue_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [jbps_pkg::BYTE_W-1:0]   m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    logic [JOB_W-1:0]             cur_data_reg;
    logic [CNT_W-1:0]             cur_left_reg;
    logic                         stuff_pend_reg;
    logic                         out_valid_reg;
    logic [jbps_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                         out_stuff_reg;
    logic                         out_last_reg;

    logic                         active;
    logic                         out_free;
    logic                         emit;
    logic [jbps_pkg::BYTE_W-1:0]  top_byte;
    logic                         need_stuff;

    assign active     = (cur_left_reg != '0) || stuff_pend_reg;
    assign out_free   = !out_valid_reg || m_tready;
    assign emit       = active && out_free;
    assign queue_pop  = !active && !queue_empty;
    assign top_byte   = cur_data_reg[JOB_W-1 -: jbps_pkg::BYTE_W];
    assign need_stuff = (top_byte == jbps_pkg::BYTE_MARKER) && stuff_enable;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_stuff_reg;
    assign m_tlast  = out_last_reg;

    // Job sequencing: load a job when idle, then one byte or stuffed zero per cycle while the output is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_left_reg   <= '0;
            stuff_pend_reg <= 1'b0;
        end else if (queue_pop) begin
            cur_left_reg <= job_count;
        end else if (emit) begin
            if (stuff_pend_reg) begin
                stuff_pend_reg <= 1'b0;
            end else begin
                cur_left_reg   <= cur_left_reg - CNT_W'(1);
                stuff_pend_reg <= need_stuff;
            end
        end
    end

    // Byte shifter: the next byte always sits at the top.
    always_ff @(posedge aclk) begin
        if (queue_pop) begin
            cur_data_reg <= job_data;
        end else if (emit && !stuff_pend_reg) begin
            cur_data_reg <= cur_data_reg << jbps_pkg::BYTE_W;
        end
    end

    // Output register decouples the sequencer from a stalled receiver.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            if (stuff_pend_reg) begin
                out_byte_reg  <= jbps_pkg::BYTE_STUFF;
                out_stuff_reg <= 1'b1;
                out_last_reg  <= (cur_left_reg == '0);
            end else begin
                out_byte_reg  <= top_byte;
                out_stuff_reg <= 1'b0;
                out_last_reg  <= (cur_left_reg == CNT_W'(1)) && !need_stuff;
            end
        end
    end

endmodule

// ===== sv/jpeg_bit_packer_byte_stuffing.sv =====
// Bit packer for an entropy coded segment, with optional zero stuffing.
//
// Requests arrive on the s_ channel: a code word of up to 24 bits, right
// aligned, and its length. Bits are appended most significant first behind
// up to seven bits left from earlier requests. Every whole byte leaves on the
// m_ channel, oldest first; with stuffing enabled each 0xFF byte is followed
// by an inserted 0x00 flagged on m_tuser. m_tlast marks the final byte of a
// request. A request that completes no byte produces nothing.
//
// A front end classifies each request in its accept cycle and pushes a job
// into a two-entry queue; a back end drains jobs into an output register,
// one byte per cycle while that register is free. Each job is loaded, then
// its bytes and stuffed zeros go out in turn; this sequencer sets the rate.
// When the receiver stalls, the output register holds, the back end waits,
// and s_tready falls once the queue is full. Reset clears the pending bits,
// the queue and the output, and sets stuffing enabled. cfg_we writes bit
// cfg_wdata as the stuffing enable; the user must do so only while the
// block is idle, as the block itself does not enforce it.
module jpeg_bit_packer_byte_stuffing #(
    parameter int MAX_CODE_LEN = jbps_pkg::MAX_CODE_LEN_DEF,
    parameter int QUEUE_DEPTH  = jbps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic                               cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // code_word [23:0], code_len [28:24], zero [31:29]
    input  logic [jbps_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_byte [7:0]
    output logic [jbps_pkg::BYTE_W-1:0]        m_tdata,
    // is_stuffing [0]
    output logic                               m_tuser,
    output logic                               m_tlast
);

    localparam int ACC_W  = MAX_CODE_LEN + jbps_pkg::PEND_W;
    localparam int NB_MAX = ACC_W / 8;
    localparam int JOB_W  = NB_MAX * 8;
    localparam int CNT_W  = $clog2(NB_MAX + 1);

    logic              stuff_enable_reg;
    logic              job_push;
    logic              queue_pop;
    logic              queue_full;
    logic              queue_empty;
    logic [JOB_W-1:0]  push_data;
    logic [CNT_W-1:0]  push_count;
    logic [JOB_W-1:0]  pop_data;
    logic [CNT_W-1:0]  pop_count;

    // Stuffing enable register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stuff_enable_reg <= jbps_pkg::STUFF_ENABLE_RST;
        end else if (cfg_we) begin
            stuff_enable_reg <= cfg_wdata;
        end
    end

    jbps_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .ACC_W        (ACC_W),
        .NB_MAX       (NB_MAX),
        .JOB_W        (JOB_W),
        .CNT_W        (CNT_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_tvalid),
        .code_word  (s_tdata[jbps_pkg::CODE_WORD_W-1:0]),
        .code_len   (s_tdata[jbps_pkg::CODE_WORD_W +: jbps_pkg::CODE_LEN_W]),
        .queue_full (queue_full),
        .req_ready  (s_tready),
        .job_push   (job_push),
        .job_data   (push_data),
        .job_count  (push_count)
    );

    jbps_fifo #(
        .WIDTH (JOB_W + CNT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data ({push_count, push_data}),
        .pop       (queue_pop),
        .pop_data  ({pop_count, pop_data}),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    jbps_back #(
        .JOB_W (JOB_W),
        .CNT_W (CNT_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .stuff_enable (stuff_enable_reg),
        .queue_empty  (queue_empty),
        .job_data     (pop_data),
        .job_count    (pop_count),
        .queue_pop    (queue_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule
